// ===== src/mme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, codes and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int DEF_MAX_DIM = 8;   // default largest matrix dimension
   localparam int DIM_W       = 4;   // width of a dimension register
   localparam int IDX_W       = 3;   // width of a row or column field
   localparam int VAL_W       = 32;  // element and product width

   // input word kinds, carried on req_tuser
   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_START  = 2'd2,
      CMD_NONE   = 2'd3
   } mme_cmd_type;

   // register indexes, byte address is four times the index
   typedef enum logic [1:0] {
      REG_ROWS_A = 2'd0,
      REG_COLS_A = 2'd1,
      REG_ROWS_B = 2'd2,
      REG_COLS_B = 2'd3
   } mme_reg_type;

   // result status, carried on rsp_tuser
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // control that travels beside one a/b element pair through the mac
   typedef struct packed {
      logic valid;
      logic first_k;
      logic last_k;
   } mme_ctrl_type;

   // zero counts as one, values above the store size saturate
   function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v,
                                                input int max_dim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_W'(max_dim);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== src/mme_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate unit: registered multiply, then a wrapping 32-bit sum.
// ----------------------------------------------------------------------------
module mme_mac
   import mme_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mme_ctrl_type     ctrl,
   input  logic [VAL_W-1:0] a_data,
   input  logic [VAL_W-1:0] b_data,
   output logic [VAL_W-1:0] sum,
   output logic             sum_done
);

   logic [VAL_W-1:0] prod_ff, prod_in;
   mme_ctrl_type     prod_ctrl_ff;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic             done_ff, done_in;

   // low 32 bits are the same for signed and unsigned operands
   assign prod_in = VAL_W'(a_data * b_data);

   always_comb begin
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (prod_ctrl_ff.valid) begin
         acc_in  = prod_ctrl_ff.first_k ? prod_ff : VAL_W'(acc_ff + prod_ff);
         done_in = prod_ctrl_ff.last_k;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         prod_ctrl_ff <= '0;
         acc_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         prod_ctrl_ff <= ctrl;
         acc_ff       <= acc_in;
         done_ff      <= done_in;
      end
   end

   assign sum      = acc_ff;
   assign sum_done = done_ff;

endmodule

// ===== src/matrix_multiply_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// Integer matrix multiply over two element stores with a streaming result.
// ----------------------------------------------------------------------------
// Load words (kind 0 for A, 1 for B) write one element each and are taken one
// per cycle while the block is idle; they give no result. A start word (kind 2)
// multiplies the rows_a x cols_a matrix A by the rows_b x cols_b matrix B and
// streams the product in row-major order, tlast on the final element. If cols_a
// differs from rows_b a single word with status set is sent instead. Dimension
// registers count zero as one and saturate at MAX_DIM. Each store has one read
// port and there is a single multiplier, so each product element is built from
// cols_a reads through the read, multiply and accumulate registers, and the
// next element's reads begin only once its sum is in the output register. A
// start occupies the block until its last sum is there, including any stall on
// the result side; no new word is taken meanwhile. Registers must be written
// only while the block is idle; the block itself does not enforce this.
module matrix_multiply_engine_core
   import mme_pkg::*;
#(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row[2:0], col[5:3], value[37:6], zero[39:38]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_row[2:0], out_col[5:3], product[37:6], zero[39:38]
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // status[0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_ERR   = 4'b1000
   } state_type;

   // ---------------- register port ----------------
   logic [DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic             csr_write;
   mme_reg_type      csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = mme_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_W'(1);
         cols_a_ff <= DIM_W'(1);
         rows_b_ff <= DIM_W'(1);
         cols_b_ff <= DIM_W'(1);
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_ROWS_A: rows_a_ff <= csr_pwdata[DIM_W-1:0];
            REG_COLS_A: cols_a_ff <= csr_pwdata[DIM_W-1:0];
            REG_ROWS_B: rows_b_ff <= csr_pwdata[DIM_W-1:0];
            REG_COLS_B: cols_b_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_ROWS_A: csr_prdata = 32'(rows_a_ff);
         REG_COLS_A: csr_prdata = 32'(cols_a_ff);
         REG_ROWS_B: csr_prdata = 32'(rows_b_ff);
         REG_COLS_B: csr_prdata = 32'(cols_b_ff);
         default:    csr_prdata = '0;
      endcase
   end

   logic [DIM_W-1:0] ra, ca, rb, cb;
   assign ra = dim_of(rows_a_ff, MAX_DIM);
   assign ca = dim_of(cols_a_ff, MAX_DIM);
   assign rb = dim_of(rows_b_ff, MAX_DIM);
   assign cb = dim_of(cols_b_ff, MAX_DIM);

   // ---------------- input decode ----------------
   mme_cmd_type      req_cmd;
   logic [IDX_W-1:0] req_row, req_col;
   logic [VAL_W-1:0] req_value;
   logic             req_fire, req_in_range;
   logic [ADDR_W-1:0] wr_addr;

   assign req_cmd      = mme_cmd_type'(req_tuser);
   assign req_row      = req_tdata[2:0];
   assign req_col      = req_tdata[5:3];
   assign req_value    = req_tdata[37:6];
   assign req_fire     = req_tvalid & req_tready;
   assign req_in_range = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign wr_addr      = ADDR_W'(32'(req_row) * MAX_DIM + 32'(req_col));

   // ---------------- sequencer ----------------
   state_type        state_ff, state_in;
   logic [DIM_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             sum_ready_ff, sum_ready_in;
   mme_ctrl_type     issue_ctrl, rd_ctrl_ff;
   logic             out_free, load_sum, load_err, elem_last;
   logic [VAL_W-1:0] mac_sum;
   logic             mac_done;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign elem_last  = ((i_ff + DIM_W'(1)) == ra) && ((j_ff + DIM_W'(1)) == cb);
   assign load_sum   = (state_ff == ST_DRAIN) & sum_ready_ff & out_free;
   assign load_err   = (state_ff == ST_ERR) & out_free;

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      issue_ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_cmd == CMD_START) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               state_in = (ca != rb) ? ST_ERR : ST_RUN;
            end
         end
         ST_RUN: begin
            issue_ctrl.valid   = 1'b1;
            issue_ctrl.first_k = (k_ff == '0);
            issue_ctrl.last_k  = ((k_ff + DIM_W'(1)) == ca);
            if (issue_ctrl.last_k) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (load_sum) begin
               k_in = '0;
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else if ((j_ff + DIM_W'(1)) == cb) begin
                  j_in = '0;
                  i_in = i_ff + DIM_W'(1);
                  state_in = ST_RUN;
               end else begin
                  j_in = j_ff + DIM_W'(1);
                  state_in = ST_RUN;
               end
            end
         end
         ST_ERR: begin
            if (load_err) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sum_ready_in = sum_ready_ff;
      if (load_sum) begin
         sum_ready_in = 1'b0;
      end else if (mac_done) begin
         sum_ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ready_ff <= 1'b0;
         rd_ctrl_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ready_ff <= sum_ready_in;
         rd_ctrl_ff   <= issue_ctrl;
      end
   end

   // ---------------- element stores ----------------
   logic [VAL_W-1:0]  store_a [DEPTH];
   logic [VAL_W-1:0]  store_b [DEPTH];
   logic [VAL_W-1:0]  rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

   assign rd_addr_a = ADDR_W'(32'(i_ff) * MAX_DIM + 32'(k_ff));
   assign rd_addr_b = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(j_ff));

   always_ff @(posedge clock) begin
      if (req_fire && req_in_range && req_cmd == CMD_LOAD_A) begin
         store_a[wr_addr] <= req_value;
      end
      rd_a_ff <= store_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_in_range && req_cmd == CMD_LOAD_B) begin
         store_b[wr_addr] <= req_value;
      end
      rd_b_ff <= store_b[rd_addr_b];
   end

   mme_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rd_ctrl_ff),
      .a_data   (rd_a_ff),
      .b_data   (rd_b_ff),
      .sum      (mac_sum),
      .sum_done (mac_done)
   );

   // ---------------- output register ----------------
   logic [IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [VAL_W-1:0] rsp_prod_ff, rsp_prod_in;
   logic             rsp_last_ff, rsp_last_in, rsp_status_ff, rsp_status_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_prod_in   = rsp_prod_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      priority if (load_sum) begin
         rsp_valid_in  = 1'b1;
         rsp_row_in    = i_ff[IDX_W-1:0];
         rsp_col_in    = j_ff[IDX_W-1:0];
         rsp_prod_in   = mac_sum;
         rsp_last_in   = elem_last;
         rsp_status_in = STATUS_OK;
      end else if (load_err) begin
         rsp_valid_in  = 1'b1;
         rsp_row_in    = '0;
         rsp_col_in    = '0;
         rsp_prod_in   = '0;
         rsp_last_in   = 1'b1;
         rsp_status_in = STATUS_MISMATCH;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_prod_ff   <= rsp_prod_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_prod_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
